@@ src/edcg_pkg.sv @@
// ----------------------------------------------------------------------------
// edcg_pkg - shared types for the egress destination class gate
// destination class and verdict codes, socket family codes, channel payloads
// ----------------------------------------------------------------------------
package edcg_pkg;

  localparam logic [15:0] FAM_INET  = 16'd2;
  localparam logic [15:0] FAM_INET6 = 16'd10;

  typedef enum logic [2:0] {
    CLS_LOOPBACK  = 3'd0,
    CLS_LINKLOCAL = 3'd1,
    CLS_PRIVATE   = 3'd2,
    CLS_PUBLIC    = 3'd3,
    CLS_OTHER     = 3'd4
  } dest_class_e;

  typedef enum logic [1:0] {
    VERDICT_ALLOW  = 2'd0,
    VERDICT_DENIED = 2'd1,
    VERDICT_PRIOR  = 2'd2
  } verdict_e;

  typedef struct packed {
    logic        prior_denied;
    logic        address_present;
    logic [15:0] address_family;
    logic [31:0] ipv4_address;
    logic [63:0] ipv6_upper;
    logic [63:0] ipv6_lower;
    logic        trusted_member;
    logic        manifest_present;
    logic [4:0]  manifest_mask;
  } edcg_req_t;

  typedef struct packed {
    dest_class_e dest_class;
    logic        log_valid;
    logic        would_deny;
    logic        enforcing;
    verdict_e    verdict;
  } edcg_rsp_t;

endpackage

@@ src/edcg_req_if.sv @@
// ----------------------------------------------------------------------------
// edcg_req_if - connect attempt channel
// valid/ready channel carrying one connect attempt per transfer
// ----------------------------------------------------------------------------
interface edcg_req_if import edcg_pkg::*; ();

  logic      valid;
  logic      ready;
  edcg_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ src/edcg_rsp_if.sv @@
// ----------------------------------------------------------------------------
// edcg_rsp_if - gate decision channel
// valid/ready channel carrying one class and verdict per transfer
// ----------------------------------------------------------------------------
interface edcg_rsp_if import edcg_pkg::*; ();

  logic      valid;
  logic      ready;
  edcg_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ src/egress_destination_class_gate.sv @@
// ----------------------------------------------------------------------------
// egress_destination_class_gate - outbound connect policy gate
// classifies the destination of each connect attempt and decides
// allow / deny against the caller's egress manifest
// ----------------------------------------------------------------------------
// Each transfer on req_i is one connect attempt and yields exactly one
// transfer on rsp_o, in order. The block is a two-register pipeline: the
// attempt is captured in an input register, classified and judged by a short
// compare ladder, and the decision lands in an output register. A new attempt
// is taken every cycle while rsp_o.ready holds, and back-pressure on rsp_o
// stalls both stages, with req_i.ready following rsp_o.ready combinationally
// when the pipe is full. Classes: ipv4 127/8 loopback, 169.254/16 link-local,
// 10/8, 172.16/12, 192.168/16 and 100.64/10 private, else public; ipv6 ::1
// loopback, ::ffff:0:0/96 by its embedded ipv4 address, fe80::/10
// link-local, fc00::/7 private, else public; no address or a non-inet family
// is other. A prior deny passes straight through with verdict prior, class
// field zero and nothing logged. Trusted callers are always allowed unless a
// prior deny is set. When a manifest is present and lacks the class the
// attempt is a would-deny, and becomes a deny only while enforce_armed is set.
// Write cfg_we_i/cfg_wdata_i only while no attempt is in flight.
// ----------------------------------------------------------------------------
module egress_destination_class_gate import edcg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  edcg_req_if.sink   req_i,
  edcg_rsp_if.source rsp_o
);

  // enforcement arm register
  logic enforce_armed_q;

  // stage 1: captured attempt
  logic      s1_valid_q;
  logic      s1_valid_d;
  edcg_req_t s1_data_q;

  // stage 2: registered decision
  logic      s2_valid_q;
  logic      s2_valid_d;
  edcg_rsp_t s2_data_q;
  edcg_rsp_t s2_data_d;

  logic        s2_adv;
  logic        s1_adv;
  dest_class_e s1_class;
  logic        s1_would_deny;
  logic        s1_enforcing;

  // pipeline flow: a stage moves when it is empty or its successor moves
  assign s2_adv      = !s2_valid_q || rsp_o.ready;
  assign s1_adv      = !s1_valid_q || s2_adv;
  assign req_i.ready = s1_adv;

  assign s1_valid_d = s1_adv ? req_i.valid : s1_valid_q;
  assign s2_valid_d = s2_adv ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enforce_armed_q <= 1'b0;
      s1_valid_q      <= 1'b0;
      s2_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enforce_armed_q <= cfg_wdata_i;
      end
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s1_adv && req_i.valid) begin
      s1_data_q <= req_i.data;
    end
    if (s2_adv && s1_valid_q) begin
      s2_data_q <= s2_data_d;
    end
  end

  // address scope classification
  edcg_classify u_classify (
    .address_present_i (s1_data_q.address_present),
    .address_family_i  (s1_data_q.address_family),
    .ipv4_address_i    (s1_data_q.ipv4_address),
    .ipv6_upper_i      (s1_data_q.ipv6_upper),
    .ipv6_lower_i      (s1_data_q.ipv6_lower),
    .dest_class_o      (s1_class)
  );

  // manifest check: class bit clear in a present manifest, caller untrusted
  assign s1_would_deny = !s1_data_q.trusted_member && s1_data_q.manifest_present &&
                         !s1_data_q.manifest_mask[s1_class];
  assign s1_enforcing  = s1_would_deny && enforce_armed_q;

  always_comb begin
    if (s1_data_q.prior_denied) begin
      // earlier check already refused: pass through, no event
      s2_data_d.dest_class = CLS_LOOPBACK;
      s2_data_d.log_valid  = 1'b0;
      s2_data_d.would_deny = 1'b0;
      s2_data_d.enforcing  = 1'b0;
      s2_data_d.verdict    = VERDICT_PRIOR;
    end else begin
      s2_data_d.dest_class = s1_class;
      s2_data_d.log_valid  = 1'b1;
      s2_data_d.would_deny = s1_would_deny;
      s2_data_d.enforcing  = s1_enforcing;
      s2_data_d.verdict    = s1_enforcing ? VERDICT_DENIED : VERDICT_ALLOW;
    end
  end

  assign rsp_o.valid = s2_valid_q;
  assign rsp_o.data  = s2_data_q;

  // a deny here always comes with a would-deny
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.data.enforcing) |->
      (rsp_o.data.would_deny && rsp_o.data.verdict == VERDICT_DENIED))
    else $error("enforcing decision without would-deny or deny verdict");

  // only a prior deny suppresses the event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.data.log_valid) |->
      (rsp_o.data.verdict == VERDICT_PRIOR && !rsp_o.data.would_deny &&
       rsp_o.data.dest_class == CLS_LOOPBACK))
    else $error("unlogged decision that is not a clean prior deny");

  // no allow verdict on an armed would-deny
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.data.would_deny && rsp_o.data.verdict == VERDICT_ALLOW) |->
      !rsp_o.data.enforcing)
    else $error("allow verdict on an enforced would-deny");

  // a stalled stage 1 item must not be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_adv) |=> s1_valid_q)
    else $error("stage 1 item dropped under back-pressure");

endmodule

@@ src/edcg_classify.sv @@
// ----------------------------------------------------------------------------
// edcg_classify - destination address scope classifier
// sorts an ipv4 or ipv6 destination into loopback, link-local, private,
// public or other
// ----------------------------------------------------------------------------
module edcg_classify import edcg_pkg::*; (
  input  logic        address_present_i,
  input  logic [15:0] address_family_i,
  input  logic [31:0] ipv4_address_i,
  input  logic [63:0] ipv6_upper_i,
  input  logic [63:0] ipv6_lower_i,
  output dest_class_e dest_class_o
);

  localparam logic [31:0] V4_MAPPED_TAG = 32'h0000_ffff;

  logic        is_v4;
  logic        is_v6;
  logic        v6_upper_zero;
  logic        v6_loopback;
  logic        v6_mapped;
  logic        v6_linklocal;
  logic        v6_private;
  logic [31:0] v4_addr;
  logic [7:0]  o1;
  logic [7:0]  o2;
  dest_class_e v4_class;

  assign is_v4 = (address_family_i == FAM_INET);
  assign is_v6 = (address_family_i == FAM_INET6);

  assign v6_upper_zero = (ipv6_upper_i == 64'd0);
  assign v6_loopback   = v6_upper_zero && (ipv6_lower_i == 64'd1);
  assign v6_mapped     = v6_upper_zero && (ipv6_lower_i[63:32] == V4_MAPPED_TAG);
  // fe80::/10
  assign v6_linklocal  = (ipv6_upper_i[63:56] == 8'hfe) && (ipv6_upper_i[55:54] == 2'b10);
  // fc00::/7
  assign v6_private    = (ipv6_upper_i[63:57] == 7'b1111_110);

  // one ipv4 ladder, shared by native ipv4 and ipv4-mapped ipv6
  assign v4_addr = is_v4 ? ipv4_address_i : ipv6_lower_i[31:0];
  assign o1      = v4_addr[31:24];
  assign o2      = v4_addr[23:16];

  always_comb begin
    if (o1 == 8'd127) begin
      v4_class = CLS_LOOPBACK;
    end else if (o1 == 8'd169 && o2 == 8'd254) begin
      v4_class = CLS_LINKLOCAL;
    end else if (o1 == 8'd10) begin
      v4_class = CLS_PRIVATE;
    end else if (o1 == 8'd172 && o2[7:4] == 4'h1) begin
      v4_class = CLS_PRIVATE;
    end else if (o1 == 8'd192 && o2 == 8'd168) begin
      v4_class = CLS_PRIVATE;
    end else if (o1 == 8'd100 && o2[7:6] == 2'b01) begin
      v4_class = CLS_PRIVATE;
    end else begin
      v4_class = CLS_PUBLIC;
    end
  end

  always_comb begin
    if (!address_present_i) begin
      dest_class_o = CLS_OTHER;
    end else if (is_v4) begin
      dest_class_o = v4_class;
    end else if (is_v6) begin
      if (v6_loopback) begin
        dest_class_o = CLS_LOOPBACK;
      end else if (v6_mapped) begin
        dest_class_o = v4_class;
      end else if (v6_linklocal) begin
        dest_class_o = CLS_LINKLOCAL;
      end else if (v6_private) begin
        dest_class_o = CLS_PRIVATE;
      end else begin
        dest_class_o = CLS_PUBLIC;
      end
    end else begin
      dest_class_o = CLS_OTHER;
    end
  end

endmodule
